>>> rtl/clsr_pkg.sv
// Package for the combined shuffled LCG generator.
// Types, state encoding and generator constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package clsr_pkg;

  localparam logic [30:0] MOD1      = 31'd2147483563;
  localparam logic [30:0] MOD2      = 31'd2147483399;
  localparam logic [15:0] MULT1     = 16'd40014;
  localparam logic [15:0] MULT2     = 16'd40692;
  // 2^31 mod MOD1 and 2^31 mod MOD2
  localparam logic [7:0]  FOLD1     = 8'd85;
  localparam logic [7:0]  FOLD2     = 8'd249;
  localparam logic [30:0] OUT_SPAN  = 31'd2147483562;
  localparam logic [30:0] SCALE_CAP = 31'd2147483537;
  localparam int          WARMUP    = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_RUN,
    ST_D_SLOT,
    ST_D_FIX,
    ST_D_M1,
    ST_D_M2,
    ST_D_COMB,
    ST_D_PROD,
    ST_D_SCL1,
    ST_D_SCL2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic        gen2;
    logic [30:0] x;
  } mm_req_t;

  typedef struct packed {
    logic        start;
    logic [61:0] num;
  } div_req_t;

endpackage
`default_nettype wire

>>> rtl/clsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module clsr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/clsr_modmul.sv
// Three-stage modular multiplier for both generators: multiply, fold the
// high part by 2^31 mod M, one conditional subtract. Uses clsr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module clsr_modmul (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire clsr_pkg::mm_req_t req,
  output logic                  done,
  output logic           [30:0] res
);
  import clsr_pkg::*;

  logic [46:0] p_r;
  logic [31:0] f_r;
  logic        g1_r, g2_r;
  logic        v1_r, v2_r, done_r;
  logic [30:0] res_r;
  logic [15:0] mult;
  logic [23:0] hi_fold;
  logic [30:0] modv;

  assign mult    = req.gen2 ? MULT2 : MULT1;
  assign hi_fold = p_r[46:31] * (g1_r ? FOLD2 : FOLD1);
  assign modv    = g2_r ? MOD2 : MOD1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req.start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
    p_r  <= 47'(req.x) * 47'(mult);
    g1_r <= req.gen2;
    f_r  <= 32'(hi_fold) + 32'(p_r[30:0]);
    g2_r <= g1_r;
    if (f_r >= {1'b0, modv}) begin
      res_r <= 31'(f_r - {1'b0, modv});
    end else begin
      res_r <= f_r[30:0];
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

>>> rtl/clsr_div.sv
// Three-stage divider of a 62-bit product by MOD1: folds the high part by
// 2^31 mod MOD1 twice, then one compare. Uses clsr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module clsr_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire clsr_pkg::div_req_t req,
  output logic                   done,
  output logic            [30:0] quo
);
  import clsr_pkg::*;

  logic        v1_r, v2_r, done_r;
  logic [37:0] t1_r;
  logic [31:0] t2_r;
  logic [30:0] q1_r, q_r;
  logic [31:0] q2_r;
  logic [37:0] fold1;
  logic [31:0] fold2;

  // num = H*2^31 + L = H*MOD1 + (H*FOLD1 + L)
  assign fold1 = 38'(req.num[61:31]) * 38'(FOLD1) + 38'(req.num[30:0]);
  assign fold2 = 32'(t1_r[37:31]) * 32'(FOLD1) + 32'(t1_r[30:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req.start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
    t1_r <= fold1;
    q1_r <= req.num[61:31];
    t2_r <= fold2;
    q2_r <= {1'b0, q1_r} + 32'(t1_r[37:31]);
    q_r  <= 31'(q2_r + 32'(t2_r >= {1'b0, MOD1}));
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

>>> rtl/combined_lcg_shuffle_rng.sv
// Combined L'Ecuyer generator with Bays-Durham shuffle table (top level).
// Uses clsr_pkg, clsr_modmul, clsr_div and clsr_ram.
//
// Input channel (in_valid/in_stall): req_type 0 seeds both generators from
// the seed_value register and fills the table; req_type 1 draws one value
// scaled to 0..range_max. Every transfer yields exactly one result on the
// output channel (out_valid/out_stall). One request is processed at a time;
// in_stall is high from acceptance until the result is loaded into the
// output register, and the next request is taken in the cycle after that.
// Seed: TABLE_DEPTH+8 steps on the shared modular multiplier, then the result
// is loaded into the output register.
// Draw: table slot by reciprocal multiply and one correction, two modular
// multiplies, combine, product, and a fold divide; then the result is loaded.
// A draw before any seed loads zeros.
// Reset: generators at 1, unseeded, seed_value 1; table contents undefined.
// While out_stall holds a result, a finished next result waits internally.
// Config: APB, seed_value at addresses 0-3 (paddr[2] low), pready always high.
`timescale 1ns / 1ps
`default_nettype none
module combined_lcg_shuffle_rng #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [30:0] in_range_max,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [30:0] out_raw_value,
  output logic      [30:0] out_scaled_index,
  output logic             out_seed_done,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import clsr_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + WARMUP);
  localparam logic [30:0] SLOT_DIV = 31'(1 + 2147483562 / TABLE_DEPTH);
  localparam logic [7:0]  SLOT_RCP = 8'((64'd1 << 31) / 64'(SLOT_DIV));

  state_t      state_r, state_nxt;
  logic [30:0] seed_r;
  logic [30:0] x1_r, x1_nxt, x2_r, x2_nxt, last_r, last_nxt;
  logic        seeded_r, seeded_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [7:0]  qe_r, qe_nxt;
  logic [30:0] slm_r, slm_nxt;
  logic [30:0] rmax_r, rmax_nxt;
  logic [61:0] prod_r, prod_nxt;
  logic [30:0] rraw_r, rraw_nxt, rscl_r, rscl_nxt;
  logic        rdone_r, rdone_nxt;
  logic        ov_r, ov_nxt;
  logic [30:0] oraw_r, oraw_nxt, oscl_r, oscl_nxt;
  logic        odone_r, odone_nxt;

  mm_req_t     mm_req;
  logic        mm_done;
  logic [30:0] mm_res;
  div_req_t    dv_req;
  logic        dv_done;
  logic [30:0] dv_quo;

  logic          we;
  logic [AW-1:0] waddr;
  logic [30:0]   wdata, rdata;

  logic [30:0] seed_eff, capped;
  logic [32:0] comb;
  logic [31:0] rng1;
  logic [62:0] pfull;
  logic [38:0] qprod, mprod;
  logic [30:0] slot_rem;
  logic [7:0]  slot_q;

  clsr_modmul u_mm (.clk, .rst_n, .req(mm_req), .done(mm_done), .res(mm_res));
  clsr_div    u_dv (.clk, .rst_n, .req(dv_req), .done(dv_done), .quo(dv_quo));
  clsr_ram #(.WIDTH(31), .DEPTH(TABLE_DEPTH), .AW(AW)) u_tbl (
    .clk, .we, .waddr, .wdata, .raddr(slot_r), .rdata
  );

  assign pready = 1'b1;
  assign prdata = {1'b0, seed_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 31'd1;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      seed_r <= pwdata[30:0];
    end
  end

  assign seed_eff = (seed_r == '0) ? 31'd1 : seed_r;
  assign capped   = (last_r > SCALE_CAP) ? SCALE_CAP : last_r;
  assign rng1     = {1'b0, rmax_r} + 32'd1;
  assign pfull    = {32'b0, capped} * {31'b0, rng1};
  assign comb     = {2'b0, rdata} - {2'b0, x2_r};
  // slot estimate is exact or one low; one compare fixes it
  assign qprod    = {8'b0, last_r} * {31'b0, SLOT_RCP};
  assign mprod    = {31'b0, qe_r} * {8'b0, SLOT_DIV};
  assign slot_rem = last_r - slm_r;
  assign slot_q   = (slot_rem >= SLOT_DIV) ? qe_r + 8'd1 : qe_r;

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = ov_r;
  assign out_raw_value    = oraw_r;
  assign out_scaled_index = oscl_r;
  assign out_seed_done    = odone_r;

  always_comb begin
    state_nxt  = state_r;
    x1_nxt     = x1_r;
    x2_nxt     = x2_r;
    last_nxt   = last_r;
    seeded_nxt = seeded_r;
    cnt_nxt    = cnt_r;
    slot_nxt   = slot_r;
    qe_nxt     = qe_r;
    slm_nxt    = slm_r;
    rmax_nxt   = rmax_r;
    prod_nxt   = prod_r;
    rraw_nxt   = rraw_r;
    rscl_nxt   = rscl_r;
    rdone_nxt  = rdone_r;
    ov_nxt     = ov_r && out_stall;
    oraw_nxt   = oraw_r;
    oscl_nxt   = oscl_r;
    odone_nxt  = odone_r;
    mm_req     = '{start: 1'b0, gen2: 1'b0, x: x1_r};
    dv_req     = '{start: 1'b0, num: prod_r};
    we         = 1'b0;
    waddr      = slot_r;
    wdata      = x1_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rmax_nxt = in_range_max;
          if (!in_req_type) begin
            x1_nxt    = seed_eff;
            x2_nxt    = seed_eff;
            cnt_nxt   = CW'(TABLE_DEPTH + WARMUP - 1);
            mm_req    = '{start: 1'b1, gen2: 1'b0, x: seed_eff};
            state_nxt = ST_S_RUN;
          end else if (seeded_r) begin
            qe_nxt    = qprod[38:31];
            state_nxt = ST_D_SLOT;
          end else begin
            rraw_nxt  = '0;
            rscl_nxt  = '0;
            rdone_nxt = 1'b0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_S_RUN: begin
        if (mm_done) begin
          x1_nxt = mm_res;
          if (cnt_r < CW'(TABLE_DEPTH)) begin
            we    = 1'b1;
            waddr = cnt_r[AW-1:0];
            wdata = mm_res;
          end
          if (cnt_r == '0) begin
            last_nxt   = mm_res;
            seeded_nxt = 1'b1;
            rraw_nxt   = '0;
            rscl_nxt   = '0;
            rdone_nxt  = 1'b1;
            state_nxt  = ST_DONE;
          end else begin
            cnt_nxt = cnt_r - CW'(1);
            mm_req  = '{start: 1'b1, gen2: 1'b0, x: mm_res};
          end
        end
      end
      ST_D_SLOT: begin
        slm_nxt   = mprod[30:0];
        state_nxt = ST_D_FIX;
      end
      ST_D_FIX: begin
        slot_nxt  = (slot_q >= 8'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1) : slot_q[AW-1:0];
        mm_req    = '{start: 1'b1, gen2: 1'b0, x: x1_r};
        state_nxt = ST_D_M1;
      end
      ST_D_M1: begin
        if (mm_done) begin
          x1_nxt    = mm_res;
          mm_req    = '{start: 1'b1, gen2: 1'b1, x: x2_r};
          state_nxt = ST_D_M2;
        end
      end
      ST_D_M2: begin
        if (mm_done) begin
          x2_nxt    = mm_res;
          state_nxt = ST_D_COMB;
        end
      end
      ST_D_COMB: begin
        we    = 1'b1;
        waddr = slot_r;
        wdata = x1_r;
        if (comb[32] || comb == '0) begin
          last_nxt = 31'(comb + {2'b0, OUT_SPAN});
        end else begin
          last_nxt = comb[30:0];
        end
        state_nxt = ST_D_PROD;
      end
      ST_D_PROD: begin
        prod_nxt  = pfull[61:0];
        state_nxt = ST_D_SCL1;
      end
      ST_D_SCL1: begin
        dv_req.start = 1'b1;
        state_nxt    = ST_D_SCL2;
      end
      ST_D_SCL2: begin
        if (dv_done) begin
          rraw_nxt  = last_r;
          rscl_nxt  = dv_quo;
          rdone_nxt = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          oraw_nxt  = rraw_r;
          oscl_nxt  = rscl_r;
          odone_nxt = rdone_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      x1_r     <= 31'd1;
      x2_r     <= 31'd1;
      last_r   <= '0;
      seeded_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      x1_r     <= x1_nxt;
      x2_r     <= x2_nxt;
      last_r   <= last_nxt;
      seeded_r <= seeded_nxt;
      ov_r     <= ov_nxt;
    end
    cnt_r   <= cnt_nxt;
    slot_r  <= slot_nxt;
    qe_r    <= qe_nxt;
    slm_r   <= slm_nxt;
    rmax_r  <= rmax_nxt;
    prod_r  <= prod_nxt;
    rraw_r  <= rraw_nxt;
    rscl_r  <= rscl_nxt;
    rdone_r <= rdone_nxt;
    oraw_r  <= oraw_nxt;
    oscl_r  <= oscl_nxt;
    odone_r <= odone_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("accepted request did not start processing");
  a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |=> seeded_r)
    else $error("seeded flag dropped");
  a_mm_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> (state_r == ST_S_RUN || state_r == ST_D_M1 || state_r == ST_D_M2))
    else $error("multiplier result outside a multiply state");
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> (state_r == ST_D_SCL2))
    else $error("divider result outside a divide state");

endmodule
`default_nettype wire
